// ===== hw/rtl/vmf3d_pkg.sv =====
// Package for the 3-D median filter: sizes, state encoding and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package vmf3d_pkg;
  localparam int unsigned MaxX = 128;
  localparam int unsigned MaxY = 128;
  localparam int unsigned MaxZ = 64;
  localparam int unsigned VoxelBits = 16;
  localparam int unsigned AddrBits = 20;
  localparam int unsigned CntBits = 9;
  localparam int unsigned BitIdxBits = 4;

  localparam logic [2:0] RegDimX = 3'd0;
  localparam logic [2:0] RegDimY = 3'd1;
  localparam logic [2:0] RegDimZ = 3'd2;
  localparam logic [2:0] RegRadX = 3'd3;
  localparam logic [2:0] RegRadY = 3'd4;
  localparam logic [2:0] RegRadZ = 3'd5;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StSize,
    StScan,
    StDrain,
    StResolve,
    StDone
  } state_e;

  typedef struct packed {
    logic wr;
    logic load;
    logic setup;
    logic size;
    logic step;
    logic resolve;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic last_xyz;
    logic last_bit;
  } status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/vmf3d_ctrl.sv =====
// Controller state machine for the 3-D median filter.
// Depends on vmf3d_pkg.
`default_nettype none
module vmf3d_ctrl import vmf3d_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_kind_i,
  output logic         in_stall_o,
  input  wire logic    out_free_i,
  output logic         emit_o,
  input  wire status_t st_i,
  output cmd_t         cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    emit_o     = 1'b0;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_kind_i == KindLoad) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = StSetup;
          end
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StSize;
      end
      StSize: begin
        cmd_o.size = 1'b1;
        state_d    = st_i.oor ? StDone : StScan;
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (st_i.last_xyz) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StResolve;
      end
      StResolve: begin
        cmd_o.resolve = 1'b1;
        state_d       = st_i.last_bit ? StDone : StScan;
      end
      StDone: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/vmf3d_dp.sv =====
// Datapath for the 3-D median filter: voxel store, window walk and
// bitwise rank selection. Depends on vmf3d_pkg.
`default_nettype none
module vmf3d_dp import vmf3d_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output status_t                   st_o,
  input  wire logic [6:0]           pos_x_i,
  input  wire logic [6:0]           pos_y_i,
  input  wire logic [5:0]           pos_z_i,
  input  wire logic [VoxelBits-1:0] voxel_value_i,
  input  wire logic [7:0]           dim_x_i,
  input  wire logic [7:0]           dim_y_i,
  input  wire logic [6:0]           dim_z_i,
  input  wire logic [1:0]           rad_x_i,
  input  wire logic [1:0]           rad_y_i,
  input  wire logic [1:0]           rad_z_i,
  output logic [VoxelBits-1:0]      median_o,
  output logic [CntBits-1:0]        count_o,
  output logic                      oor_o
);
  logic [VoxelBits-1:0] mem_q [MaxX*MaxY*MaxZ];
  logic [VoxelBits-1:0] rd_q;
  logic                 rd_vld_q;
  logic [6:0] px_q, py_q, xb_q, yb_q, xe_q, ye_q, x_q, y_q;
  logic [5:0] pz_q, zb_q, ze_q, z_q;
  logic       oor_q;
  logic [CntBits-1:0] n_q, k_q, cnt_q;
  logic [VoxelBits-1:0] pre_q;
  logic [BitIdxBits-1:0] bit_q;

  logic [7:0] dx, dy, ex, ey, hx, hy;
  logic [6:0] dz, ez, hz;
  logic [2:0] sx, sy, sz;
  logic [CntBits-1:0] vol;
  logic [VoxelBits-1:0] hmask;
  logic       match;
  logic [AddrBits-1:0] rd_addr;

  assign dx = (dim_x_i > 8'(MaxX)) ? 8'(MaxX) : dim_x_i;
  assign dy = (dim_y_i > 8'(MaxY)) ? 8'(MaxY) : dim_y_i;
  assign dz = (dim_z_i > 7'(MaxZ)) ? 7'(MaxZ) : dim_z_i;
  assign ex = {1'b0, px_q} + {6'd0, rad_x_i};
  assign ey = {1'b0, py_q} + {6'd0, rad_y_i};
  assign ez = {1'b0, pz_q} + {5'd0, rad_z_i};
  assign hx = (ex > dx - 8'd1) ? dx - 8'd1 : ex;
  assign hy = (ey > dy - 8'd1) ? dy - 8'd1 : ey;
  assign hz = (ez > dz - 7'd1) ? dz - 7'd1 : ez;
  assign sx = 3'(xe_q - xb_q) + 3'd1;
  assign sy = 3'(ye_q - yb_q) + 3'd1;
  assign sz = 3'(ze_q - zb_q) + 3'd1;
  assign vol = CntBits'(sx) * CntBits'(sy) * CntBits'(sz);
  assign hmask = {VoxelBits{1'b1}} << ({1'b0, bit_q} + 5'd1);
  assign match = ((((rd_q ^ pre_q) & hmask) == '0) && !rd_q[bit_q]);
  assign rd_addr = {z_q, y_q, x_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[{pos_z_i, pos_y_i, pos_x_i}] <= voxel_value_i;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
    end
    if (cmd_i.setup) begin
      oor_q <= ({1'b0, px_q} >= dx) || ({1'b0, py_q} >= dy) || ({1'b0, pz_q} >= dz);
      xb_q  <= (px_q >= {5'd0, rad_x_i}) ? px_q - {5'd0, rad_x_i} : 7'd0;
      yb_q  <= (py_q >= {5'd0, rad_y_i}) ? py_q - {5'd0, rad_y_i} : 7'd0;
      zb_q  <= (pz_q >= {4'd0, rad_z_i}) ? pz_q - {4'd0, rad_z_i} : 6'd0;
      xe_q  <= hx[6:0];
      ye_q  <= hy[6:0];
      ze_q  <= hz[5:0];
    end
    if (cmd_i.size) begin
      n_q   <= vol;
      k_q   <= vol >> 1;
      pre_q <= '0;
      bit_q <= BitIdxBits'(VoxelBits - 1);
      cnt_q <= '0;
      x_q   <= xb_q;
      y_q   <= yb_q;
      z_q   <= zb_q;
    end
    if (cmd_i.step) begin
      if (x_q == xe_q) begin
        x_q <= xb_q;
        if (y_q == ye_q) begin
          y_q <= yb_q;
          z_q <= (z_q == ze_q) ? zb_q : z_q + 6'd1;
        end else begin
          y_q <= y_q + 7'd1;
        end
      end else begin
        x_q <= x_q + 7'd1;
      end
    end
    if (rd_vld_q && match) begin
      cnt_q <= cnt_q + CntBits'(1);
    end
    if (cmd_i.resolve) begin
      if (k_q >= cnt_q) begin
        pre_q[bit_q] <= 1'b1;
        k_q          <= k_q - cnt_q;
      end
      bit_q <= bit_q - BitIdxBits'(1);
      cnt_q <= '0;
    end
  end

  assign st_o.oor      = oor_q;
  assign st_o.last_xyz = (x_q == xe_q) && (y_q == ye_q) && (z_q == ze_q);
  assign st_o.last_bit = (bit_q == '0);
  assign median_o      = oor_q ? '0 : pre_q;
  assign count_o       = oor_q ? '0 : n_q;
  assign oor_o         = oor_q;
endmodule
`default_nettype wire

// ===== hw/rtl/volume_median_filter_3d_unit.sv =====
// Load item: writes the store as it is taken. Query item: the result is set by
// sixteen bitwise rank passes over the window through the single store read port;
// an off-volume query skips the passes and returns zero median and count.
// One item at a time; the next is taken the cycle after a result is registered, and a
// waiting result does not stop it. Reset clears control and restores registers; the
// voxel store is not cleared. Top level; depends on vmf3d_pkg, vmf3d_ctrl, vmf3d_dp.
`default_nettype none
module volume_median_filter_3d_unit import vmf3d_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [6:0]  pos_x_i,
  input  wire logic [6:0]  pos_y_i,
  input  wire logic [5:0]  pos_z_i,
  input  wire logic [15:0] voxel_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      median_value_o,
  output logic [8:0]       window_count_o,
  output logic             out_of_range_o
);
  logic [7:0] dim_x_q, dim_y_q;
  logic [6:0] dim_z_q;
  logic [1:0] rad_x_q, rad_y_q, rad_z_q;
  logic       out_valid_q, emit, wr_en;
  logic [15:0] med_q, med;
  logic [8:0]  cnt_q, cnt;
  logic        oor_q, oor;
  cmd_t        cmd;
  status_t     st;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= 8'd128;
      dim_y_q <= 8'd128;
      dim_z_q <= 7'd64;
      rad_x_q <= 2'd1;
      rad_y_q <= 2'd1;
      rad_z_q <= 2'd1;
    end else if (wr_en) begin
      case (paddr[4:2])
        RegDimX: dim_x_q <= pwdata[7:0];
        RegDimY: dim_y_q <= pwdata[7:0];
        RegDimZ: dim_z_q <= pwdata[6:0];
        RegRadX: rad_x_q <= pwdata[1:0];
        RegRadY: rad_y_q <= pwdata[1:0];
        RegRadZ: rad_z_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegDimX: prdata = {24'd0, dim_x_q};
      RegDimY: prdata = {24'd0, dim_y_q};
      RegDimZ: prdata = {25'd0, dim_z_q};
      RegRadX: prdata = {30'd0, rad_x_q};
      RegRadY: prdata = {30'd0, rad_y_q};
      RegRadZ: prdata = {30'd0, rad_z_q};
      default: prdata = '0;
    endcase
  end

  vmf3d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (kind_i),
    .in_stall_o (in_stall_o),
    .out_free_i (!out_valid_q || !out_stall_i),
    .emit_o     (emit),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  vmf3d_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .voxel_value_i (voxel_value_i),
    .dim_x_i       (dim_x_q),
    .dim_y_i       (dim_y_q),
    .dim_z_i       (dim_z_q),
    .rad_x_i       (rad_x_q),
    .rad_y_i       (rad_y_q),
    .rad_z_i       (rad_z_q),
    .median_o      (med),
    .count_o       (cnt),
    .oor_o         (oor)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      med_q <= med;
      cnt_q <= cnt;
      oor_q <= oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = med_q;
  assign window_count_o = cnt_q;
  assign out_of_range_o = oor_q;
endmodule
`default_nettype wire

// ===== hw/rtl/vmf3d_checker.sv =====
// Port-level checks for the 3-D median filter, bound to the top level.
// Depends on volume_median_filter_3d_unit.
`default_nettype none
module vmf3d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] median_value_o,
  input wire logic [8:0]  window_count_o,
  input wire logic        out_of_range_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_value_o))
    else $error("Stalled result changed.");
  a_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> median_value_o == 16'd0 && window_count_o == 9'd0)
    else $error("Off-volume result not zero.");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |-> window_count_o != 9'd0)
    else $error("Empty window on valid centre.");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("Register port not ready.");
endmodule

bind volume_median_filter_3d_unit vmf3d_checker u_vmf3d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .median_value_o (median_value_o),
  .window_count_o (window_count_o),
  .out_of_range_o (out_of_range_o)
);
`default_nettype wire

// ===== sim/tb_volume_median_filter_3d_unit.sv =====
// Testbench for the 3-D median filter unit: loads voxels, queries medians over
// clipped box windows and checks every result against a local prediction.
// Depends on vmf3d_pkg and the volume_median_filter_3d_unit RTL.
`default_nettype none

class median_scoreboard;
  logic [15:0] voxels [int];
  int unsigned dim_x = 128, dim_y = 128, dim_z = 64;
  int unsigned rad_x = 1, rad_y = 1, rad_z = 1;
  logic [15:0] exp_median [$];
  logic [8:0] exp_count [$];
  logic exp_oor [$];
  int errors = 0;

  function int unsigned addr_of(int unsigned x, int unsigned y, int unsigned z);
    return (z * vmf3d_pkg::MaxY + y) * vmf3d_pkg::MaxX + x;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      vmf3d_pkg::RegDimX: dim_x = val[7:0];
      vmf3d_pkg::RegDimY: dim_y = val[7:0];
      vmf3d_pkg::RegDimZ: dim_z = val[6:0];
      vmf3d_pkg::RegRadX: rad_x = val[1:0];
      vmf3d_pkg::RegRadY: rad_y = val[1:0];
      vmf3d_pkg::RegRadZ: rad_z = val[1:0];
      default: ;
    endcase
  endfunction

  function void note_item(logic kind, logic [6:0] px, logic [6:0] py, logic [5:0] pz,
                          logic [15:0] val);
    int unsigned dx, dy, dz, xb, xe, yb, ye, zb, ze, n;
    logic [15:0] win [$];
    dx = dim_x > 128 ? 128 : dim_x;
    dy = dim_y > 128 ? 128 : dim_y;
    dz = dim_z > 64 ? 64 : dim_z;
    if (kind == vmf3d_pkg::KindLoad) begin
      voxels[addr_of(px, py, pz)] = val;
      return;
    end
    if (px >= dx || py >= dy || pz >= dz) begin
      exp_median = {exp_median, 16'd0};
      exp_count = {exp_count, 9'd0};
      exp_oor = {exp_oor, 1'b1};
      return;
    end
    xb = px >= rad_x ? px - rad_x : 0;
    yb = py >= rad_y ? py - rad_y : 0;
    zb = pz >= rad_z ? pz - rad_z : 0;
    xe = (px + rad_x > dx - 1) ? dx - 1 : px + rad_x;
    ye = (py + rad_y > dy - 1) ? dy - 1 : py + rad_y;
    ze = (pz + rad_z > dz - 1) ? dz - 1 : pz + rad_z;
    for (int unsigned z = zb; z <= ze; z++)
      for (int unsigned y = yb; y <= ye; y++)
        for (int unsigned x = xb; x <= xe; x++)
          win = {win, voxels.exists(addr_of(x, y, z)) ? voxels[addr_of(x, y, z)] : 16'd0};
    win.sort();
    n = win.size();
    exp_median = {exp_median, win[n / 2]};
    exp_count = {exp_count, n[8:0]};
    exp_oor = {exp_oor, 1'b0};
  endfunction

  function void check_result(logic [15:0] med, logic [8:0] cnt, logic oor);
    if (exp_median.size() == 0) begin
      $error("unexpected result median=%0d count=%0d oor=%0d", med, cnt, oor);
      errors++;
      return;
    end
    if (med !== exp_median[0]) begin
      $error("median_value expected %0d actual %0d", exp_median[0], med);
      errors++;
    end
    if (cnt !== exp_count[0]) begin
      $error("window_count expected %0d actual %0d", exp_count[0], cnt);
      errors++;
    end
    if (oor !== exp_oor[0]) begin
      $error("out_of_range expected %0d actual %0d", exp_oor[0], oor);
      errors++;
    end
    void'(exp_median.pop_front());
    void'(exp_count.pop_front());
    void'(exp_oor.pop_front());
  endfunction

  function int pending();
    return exp_median.size();
  endfunction
endclass

module tb_volume_median_filter_3d_unit;
  import vmf3d_pkg::*;

  localparam int WatchdogLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0;
  logic [6:0] pos_x_i = '0, pos_y_i = '0;
  logic [5:0] pos_z_i = '0;
  logic [15:0] voxel_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] median_value_o;
  logic [8:0] window_count_o;
  logic out_of_range_o;

  median_scoreboard board = new();
  int idle_cycles = 0;
  int unsigned cur_dx = 128, cur_dy = 128, cur_dz = 64;

  volume_median_filter_3d_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(median_value_o, window_count_o, out_of_range_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls for a random number of cycles per item, with calm stretches.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      out_stall_i <= (n != 0);
      repeat (n) @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic send_item(logic kind, int unsigned x, int unsigned y, int unsigned z,
                           logic [15:0] val, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= kind; pos_x_i <= 7'(x); pos_y_i <= 7'(y); pos_z_i <= 6'(z);
    voxel_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(kind, 7'(x), 7'(y), 6'(z), val);
  endtask

  task automatic finish_items();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned dx, int unsigned dy, int unsigned dz,
                              int unsigned rx, int unsigned ry, int unsigned rz);
    write_reg(RegDimX, dx); write_reg(RegDimY, dy); write_reg(RegDimZ, dz);
    write_reg(RegRadX, rx); write_reg(RegRadY, ry); write_reg(RegRadZ, rz);
    cur_dx = dx; cur_dy = dy; cur_dz = dz;
  endtask

  // Loads every voxel of a small corner region so queries read only written data.
  task automatic fill_region(int unsigned nx, int unsigned ny, int unsigned nz, bit extremes);
    logic [15:0] v;
    for (int unsigned z = 0; z < nz; z++)
      for (int unsigned y = 0; y < ny; y++)
        for (int unsigned x = 0; x < nx; x++) begin
          v = extremes ? (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000)
                       : 16'($urandom);
          send_item(KindLoad, x, y, z, v, $urandom_range(0, 3) == 0);
        end
  endtask

  task automatic random_query(int unsigned nx, int unsigned ny, int unsigned nz);
    int unsigned x, y, z;
    if ($urandom_range(0, 5) == 0) begin
      x = $urandom_range(0, 127); y = $urandom_range(0, 127); z = $urandom_range(0, 63);
      if (x < cur_dx && y < cur_dy && z < cur_dz) x = cur_dx <= 127 ? cur_dx : x;
      if (x < cur_dx && y < cur_dy && z < cur_dz) z = cur_dz <= 63 ? cur_dz : z;
      if (x < cur_dx && y < cur_dy && z < cur_dz) begin
        x = 0; y = 0; z = 0;
      end
    end else begin
      x = $urandom_range(0, nx - 1); y = $urandom_range(0, ny - 1);
      z = $urandom_range(0, nz - 1);
    end
    send_item(KindQuery, x, y, z, 16'($urandom), 1'b1);
  endtask

  initial begin
    int unsigned nx, ny, nz;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corner regions at reset geometry, then extremes of the registers.
    fill_region(6, 4, 5, 1'b1);
    for (int unsigned z = 62; z <= 63; z++)
      for (int unsigned y = 126; y <= 127; y++)
        for (int unsigned x = 126; x <= 127; x++)
          send_item(KindLoad, x, y, z, 16'($urandom), 1'b0);
    send_item(KindLoad, 127, 127, 63, 16'hFFFF, 1'b0);
    send_item(KindQuery, 0, 0, 0, 16'hFFFF, 1'b0);
    send_item(KindQuery, 1, 1, 1, 16'h0000, 1'b0);
    send_item(KindQuery, 127, 127, 63, 16'h0, 1'b0);
    finish_items();
    set_geometry(1, 1, 1, 3, 3, 3);
    send_item(KindQuery, 0, 0, 0, 16'h0, 1'b0);
    send_item(KindQuery, 1, 0, 0, 16'h0, 1'b0);
    send_item(KindQuery, 127, 127, 63, 16'h0, 1'b0);
    finish_items();
    set_geometry(0, 4, 4, 0, 0, 0);
    send_item(KindQuery, 0, 0, 0, 16'h0, 1'b0);
    finish_items();
    set_geometry(255, 4, 127, 2, 3, 1);
    send_item(KindQuery, 2, 2, 2, 16'h0, 1'b0);
    send_item(KindQuery, 3, 3, 3, 16'h0, 1'b0);
    finish_items();

    // Random phases: a fresh small volume, then queries inside it and off it.
    for (int phase = 0; phase < 10; phase++) begin
      nx = $urandom_range(1, 5); ny = $urandom_range(1, 5); nz = $urandom_range(1, 4);
      set_geometry(nx, ny, nz, $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 3));
      fill_region(nx, ny, nz, phase % 3 == 0);
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_item(KindLoad, $urandom_range(0, nx - 1), $urandom_range(0, ny - 1),
                    $urandom_range(0, nz - 1), 16'($urandom), 1'b1);
        else if ($urandom_range(0, 9) == 0)
          send_item(KindLoad, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 63), 16'($urandom), 1'b1);
        else
          random_query(nx, ny, nz);
      end
      finish_items();
    end
    // Full extremes of the write coordinates are covered by loads far off the window.
    send_item(KindLoad, 127, 127, 63, 16'h0, 1'b0);
    send_item(KindLoad, 64, 64, 32, 16'h8000, 1'b0);
    finish_items();

    if (board.errors == 0 && board.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
